[design/mrxy_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_pkg
// Shared widths, codes and types of the XY mesh route unit.
// ---------------------------------------------------------------------------
package mrxy_pkg;

	localparam int COORD_W    = 3;
	localparam int TIME_W     = 32;
	localparam int HOP_W      = 4;
	localparam int LIMIT_W    = 4;
	localparam int PORT_W     = 2;
	localparam int STAT_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_Y     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 2'd2;

	localparam logic [PORT_W-1:0] PORT_EAST  = 2'd0;
	localparam logic [PORT_W-1:0] PORT_WEST  = 2'd1;
	localparam logic [PORT_W-1:0] PORT_SOUTH = 2'd2;
	localparam logic [PORT_W-1:0] PORT_NORTH = 2'd3;

	localparam logic OP_ROUTE = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ACT_EAST      = 3'd0,
		ACT_WEST      = 3'd1,
		ACT_SOUTH     = 3'd2,
		ACT_NORTH     = 3'd3,
		ACT_DELIVERED = 3'd4,
		ACT_STALLED   = 3'd5,
		ACT_DRAINED   = 3'd6,
		ACT_EMPTY     = 3'd7
	} action_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [TIME_W-1:0]  birth_time;
		logic [HOP_W-1:0]   hop_count;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
		input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[design/mrxy_pkt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_pkt_if
// Request channel: route or drain word with valid/ready.
// ---------------------------------------------------------------------------
interface mrxy_pkt_if
	import mrxy_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                op;
	logic [PORT_W-1:0]   drain_port;
	logic [COORD_W-1:0]  dest_x;
	logic [COORD_W-1:0]  dest_y;
	logic [TIME_W-1:0]   birth_time;
	logic [HOP_W-1:0]    hop_count;
	logic [TIME_W-1:0]   now_time;

	modport source (output valid, op, drain_port, dest_x, dest_y, birth_time, hop_count,
		now_time, input ready);
	modport sink (input valid, op, drain_port, dest_x, dest_y, birth_time, hop_count,
		now_time, output ready);
endinterface
`default_nettype wire

[design/mrxy_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_rsp_if
// Result channel: action, drained packet and statistics with valid/ready.
// ---------------------------------------------------------------------------
interface mrxy_rsp_if
	import mrxy_pkg::*;
();
	logic                valid;
	logic                ready;
	action_t             action;
	logic [COORD_W-1:0]  out_dest_x;
	logic [COORD_W-1:0]  out_dest_y;
	logic [TIME_W-1:0]   out_birth_time;
	logic [HOP_W-1:0]    out_hop_count;
	logic [TIME_W-1:0]   packet_latency;
	logic [STAT_W-1:0]   delivered_count;
	logic [STAT_W-1:0]   latency_total;
	logic [STAT_W-1:0]   latency_peak;
	logic [STAT_W-1:0]   stall_count;
	logic [STAT_W-1:0]   hops_total;

	modport source (output valid, action, out_dest_x, out_dest_y, out_birth_time,
		out_hop_count, packet_latency, delivered_count, latency_total, latency_peak,
		stall_count, hops_total, input ready);
	modport sink (input valid, action, out_dest_x, out_dest_y, out_birth_time,
		out_hop_count, packet_latency, delivered_count, latency_total, latency_peak,
		stall_count, hops_total, output ready);
endinterface
`default_nettype wire

[design/mrxy_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ---------------------------------------------------------------------------
interface mrxy_cfg_if
	import mrxy_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/mrxy_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_ctrl
// Sequencer: takes a word, lets the datapath commit it once the result
// register is free, and owns the result valid flag.
// ---------------------------------------------------------------------------
module mrxy_ctrl
	import mrxy_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready    = (state_q == S_IDLE);
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_EXEC) && slot_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[design/mrxy_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mrxy_dp
// Datapath: config registers, route decision, four output FIFOs in one
// memory, saturating statistics and the result register.
// ---------------------------------------------------------------------------
module mrxy_dp
	import mrxy_pkg::*;
#(
	parameter int BUFFER_DEPTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  op,
	input  wire logic [PORT_W-1:0]     drain_port,
	input  wire logic [COORD_W-1:0]    dest_x,
	input  wire logic [COORD_W-1:0]    dest_y,
	input  wire logic [TIME_W-1:0]     birth_time,
	input  wire logic [HOP_W-1:0]      hop_count,
	input  wire logic [TIME_W-1:0]     now_time,
	output action_t                    action,
	output logic [COORD_W-1:0]         out_dest_x,
	output logic [COORD_W-1:0]         out_dest_y,
	output logic [TIME_W-1:0]          out_birth_time,
	output logic [HOP_W-1:0]           out_hop_count,
	output logic [TIME_W-1:0]          packet_latency,
	output logic [STAT_W-1:0]          delivered_count,
	output logic [STAT_W-1:0]          latency_total,
	output logic [STAT_W-1:0]          latency_peak,
	output logic [STAT_W-1:0]          stall_count,
	output logic [STAT_W-1:0]          hops_total
);

	localparam int PTR_W   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int CMP_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
	localparam int ADDR_W  = PORT_W + PTR_W;
	localparam int ENTRIES = 1 << ADDR_W;
	localparam int NPORTS  = 1 << PORT_W;
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(BUFFER_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// configuration
	logic [COORD_W-1:0] router_x_q;
	logic [COORD_W-1:0] router_y_q;
	logic [LIMIT_W-1:0] limit_q;

	// fifo bookkeeping and storage
	logic [FILL_W-1:0] fill_q [NPORTS];
	logic [PTR_W-1:0]  head_q [NPORTS];
	logic [PTR_W-1:0]  tail_q [NPORTS];
	entry_t            mem_q  [ENTRIES];
	entry_t            rd_q;

	// captured word
	logic               op_q;
	logic [PORT_W-1:0]  port_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [TIME_W-1:0]  birth_q;
	logic [HOP_W-1:0]   hops_q;
	logic [TIME_W-1:0]  now_q;

	// statistics
	logic [STAT_W-1:0] delivered_q;
	logic [STAT_W-1:0] lat_sum_q;
	logic [STAT_W-1:0] lat_max_q;
	logic [STAT_W-1:0] stall_q;
	logic [STAT_W-1:0] hops_sum_q;

	// result register
	action_t            act_q;
	logic [COORD_W-1:0] odx_q;
	logic [COORD_W-1:0] ody_q;
	logic [TIME_W-1:0]  obirth_q;
	logic [HOP_W-1:0]   ohops_q;
	logic [TIME_W-1:0]  olat_q;

	logic               is_local;
	logic [PORT_W-1:0]  sel_port;
	logic [PORT_W-1:0]  cur_port;
	logic [FILL_W-1:0]  fill_cur;
	logic [CMP_W-1:0]   limit_ext;
	logic [CMP_W-1:0]   eff_limit;
	logic               room;
	logic               do_pop;
	logic               do_push;
	logic               do_stall;
	logic               do_deliver;
	logic [TIME_W-1:0]  lat;
	entry_t             wr_entry;
	action_t            act_next;

	always_comb begin
		is_local = (dx_q == router_x_q) && (dy_q == router_y_q);
		if (dx_q > router_x_q) begin
			sel_port = PORT_EAST;
		end else if (dx_q < router_x_q) begin
			sel_port = PORT_WEST;
		end else if (dy_q > router_y_q) begin
			sel_port = PORT_SOUTH;
		end else begin
			sel_port = PORT_NORTH;
		end
		cur_port   = (op_q == OP_DRAIN) ? port_q : sel_port;
		fill_cur   = fill_q[cur_port];
		limit_ext  = CMP_W'(limit_q);
		eff_limit  = (limit_ext > DEPTH_CMP) ? DEPTH_CMP : limit_ext;
		room       = CMP_W'(fill_cur) < eff_limit;
		do_pop     = (op_q == OP_DRAIN) && (fill_cur != '0);
		do_deliver = (op_q == OP_ROUTE) && is_local;
		do_push    = (op_q == OP_ROUTE) && !is_local && room;
		do_stall   = (op_q == OP_ROUTE) && !is_local && !room;
		lat        = now_q - birth_q;
		wr_entry   = '{dest_x: dx_q, dest_y: dy_q, birth_time: birth_q, hop_count: hops_q};
		if (op_q == OP_DRAIN) begin
			act_next = do_pop ? ACT_DRAINED : ACT_EMPTY;
		end else if (is_local) begin
			act_next = ACT_DELIVERED;
		end else if (room) begin
			act_next = action_t'({1'b0, sel_port});
		end else begin
			act_next = ACT_STALLED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_x_q  <= '0;
			router_y_q  <= '0;
			limit_q     <= LIMIT_RESET;
			delivered_q <= '0;
			lat_sum_q   <= '0;
			lat_max_q   <= '0;
			stall_q     <= '0;
			hops_sum_q  <= '0;
			for (int p = 0; p < NPORTS; p++) begin
				fill_q[p] <= '0;
				head_q[p] <= '0;
				tail_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROUTER_X:     router_x_q <= cfg_data[COORD_W-1:0];
					CFG_ROUTER_Y:     router_y_q <= cfg_data[COORD_W-1:0];
					CFG_BUFFER_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				for (int p = 0; p < NPORTS; p++) begin
					if (cur_port == PORT_W'(p)) begin
						if (do_pop) begin
							head_q[p] <= ptr_inc(head_q[p]);
							fill_q[p] <= fill_q[p] - FILL_W'(1);
						end
						if (do_push) begin
							tail_q[p] <= ptr_inc(tail_q[p]);
							fill_q[p] <= fill_q[p] + FILL_W'(1);
						end
					end
				end
				if (do_deliver) begin
					delivered_q <= sat_add(delivered_q, STAT_W'(1));
					lat_sum_q   <= sat_add(lat_sum_q, lat);
					hops_sum_q  <= sat_add(hops_sum_q, STAT_W'(hops_q));
					if (lat >= lat_max_q) begin
						lat_max_q <= lat;
					end
				end
				if (do_stall) begin
					stall_q <= sat_add(stall_q, STAT_W'(1));
				end
			end
		end
	end

	// fifo memory, registered read at capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= mem_q[{drain_port, head_q[drain_port]}];
		end
		if (cmd.commit && do_push) begin
			mem_q[{cur_port, tail_q[cur_port]}] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			port_q  <= drain_port;
			dx_q    <= dest_x;
			dy_q    <= dest_y;
			birth_q <= birth_time;
			hops_q  <= hop_count;
			now_q   <= now_time;
		end
		if (cmd.commit) begin
			act_q    <= act_next;
			odx_q    <= do_pop ? rd_q.dest_x : '0;
			ody_q    <= do_pop ? rd_q.dest_y : '0;
			obirth_q <= do_pop ? rd_q.birth_time : '0;
			ohops_q  <= do_pop ? rd_q.hop_count : '0;
			olat_q   <= do_deliver ? lat : '0;
		end
	end

	assign action          = act_q;
	assign out_dest_x      = odx_q;
	assign out_dest_y      = ody_q;
	assign out_birth_time  = obirth_q;
	assign out_hop_count   = ohops_q;
	assign packet_latency  = olat_q;
	assign delivered_count = delivered_q;
	assign latency_total   = lat_sum_q;
	assign latency_peak    = lat_max_q;
	assign stall_count     = stall_q;
	assign hops_total      = hops_sum_q;

endmodule
`default_nettype wire

[design/mesh_router_xy_route_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mesh_router_xy_route_unit
// One mesh router node with XY dimension-order routing into four bounded
// output FIFOs, local delivery statistics and FIFO drain.
//
//   channel  dir  handshake      word
//   pkt      in   valid/ready    op, drain_port, dest, birth, hops, now
//   rsp      out  valid/ready    action, drained packet, latency, statistics
//   cfg      in   valid/ready    register index, write data (always ready)
//
// Each word is first captured, which also reads the FIFO memory (registered
// read port), and is then decided and committed into the result register.
// The result register lets the next word be captured while a result waits;
// commit waits until that register is free.
// Reset clears FIFO pointers, fill counts and statistics; the FIFO memory
// itself is not cleared, entries are passed out only after being written.
// ---------------------------------------------------------------------------
module mesh_router_xy_route_unit
	import mrxy_pkg::*;
#(
	parameter int BUFFER_DEPTH = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrxy_pkt_if.sink    pkt,
	mrxy_rsp_if.source  rsp,
	mrxy_cfg_if.sink    cfg
);

	cmd_t cmd;

	assign cfg.ready = 1'b1;

	mrxy_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt.valid),
		.in_ready  (pkt.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	mrxy_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg.valid && cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.op              (pkt.op),
		.drain_port      (pkt.drain_port),
		.dest_x          (pkt.dest_x),
		.dest_y          (pkt.dest_y),
		.birth_time      (pkt.birth_time),
		.hop_count       (pkt.hop_count),
		.now_time        (pkt.now_time),
		.action          (rsp.action),
		.out_dest_x      (rsp.out_dest_x),
		.out_dest_y      (rsp.out_dest_y),
		.out_birth_time  (rsp.out_birth_time),
		.out_hop_count   (rsp.out_hop_count),
		.packet_latency  (rsp.packet_latency),
		.delivered_count (rsp.delivered_count),
		.latency_total   (rsp.latency_total),
		.latency_peak    (rsp.latency_peak),
		.stall_count     (rsp.stall_count),
		.hops_total      (rsp.hops_total)
	);

endmodule
`default_nettype wire
